// ===== sv/wbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word break segmenter package
// Shared operation codes, default sizes and the control bundles that the top
// level hands to the window cells and the word cells.
// ----------------------------------------------------------------------------
package wbs_pkg;

    localparam int SYM_W            = 8;
    localparam int OP_W             = 2;
    localparam int DEF_MAX_WORDS    = 64;
    localparam int DEF_MAX_WORD_LEN = 16;
    localparam int GROUP_SIZE       = 8;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_DICT  = 2'd1;
    localparam logic [OP_W-1:0] OP_TEXT  = 2'd2;

    typedef struct packed {
        logic             shift;
        logic             restart;
    } wbs_win_ctl_t;

    typedef struct packed {
        logic             clear;
        logic             shift;
        logic             commit;
        logic [SYM_W-1:0] sym;
    } wbs_load_t;

endpackage

// ===== sv/wbs_window_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word break segmenter window cell
// One position of the text window: a byte and the reach bit of the position
// behind it, both passed on to the next cell on every text byte.
// ----------------------------------------------------------------------------
module wbs_window_cell
    import wbs_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  wbs_win_ctl_t     ctl,
    input  logic [SYM_W-1:0] byte_in,
    input  logic             reach_in,
    output logic [SYM_W-1:0] byte_out,
    output logic             reach_out
);

    logic [SYM_W-1:0] byte_reg;
    logic [SYM_W-1:0] byte_next;
    logic             reach_reg;
    logic             reach_next;

    always_comb begin
        byte_next  = byte_reg;
        reach_next = reach_reg;
        priority if (ctl.restart) begin
            byte_next  = '0;
            reach_next = 1'b0;
        end else if (ctl.shift) begin
            byte_next  = byte_in;
            reach_next = reach_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg  <= '0;
            reach_reg <= 1'b0;
        end else begin
            byte_reg  <= byte_next;
            reach_reg <= reach_next;
        end
    end

    assign byte_out  = byte_reg;
    assign reach_out = reach_reg;

endmodule

// ===== sv/wbs_word_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word break segmenter word cell
// Holds one dictionary word, newest byte first, and compares it against the
// text window; the hit is registered.
// ----------------------------------------------------------------------------
module wbs_word_cell
    import wbs_pkg::*;
#(
    parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN,
    localparam int LEN_W = $clog2(MAX_WORD_LEN + 1),
    localparam int IDX_W = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1
)
(
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  wbs_load_t                            load,
    input  logic [LEN_W-1:0]                     commit_len,
    input  logic [MAX_WORD_LEN-1:0][SYM_W-1:0]   window_bytes,
    input  logic [MAX_WORD_LEN-1:0]              window_reach,
    output logic                                 hit
);

    logic [MAX_WORD_LEN-1:0][SYM_W-1:0] byte_reg;
    logic [MAX_WORD_LEN-1:0][SYM_W-1:0] byte_next;
    logic [LEN_W-1:0]                   len_reg;
    logic [LEN_W-1:0]                   len_next;
    logic                               valid_reg;
    logic                               valid_next;
    logic                               hit_reg;
    logic                               hit_next;
    logic [LEN_W-1:0]                   len_m1;
    logic                               bytes_ok;

    always_comb begin
        byte_next = byte_reg;
        if (load.shift) begin
            byte_next[0] = load.sym;
            for (int k = 1; k < MAX_WORD_LEN; k++) begin
                byte_next[k] = byte_reg[k-1];
            end
        end
    end

    always_comb begin
        len_next   = len_reg;
        valid_next = valid_reg;
        priority if (load.clear) begin
            valid_next = 1'b0;
        end else if (load.commit) begin
            valid_next = 1'b1;
            len_next   = commit_len;
        end
    end

    // The stored word is right-aligned to the newest text byte.
    always_comb begin
        bytes_ok = 1'b1;
        for (int k = 0; k < MAX_WORD_LEN; k++) begin
            if (LEN_W'(k) < len_reg && byte_reg[k] != window_bytes[k]) begin
                bytes_ok = 1'b0;
            end
        end
    end

    assign len_m1   = len_reg - 1'b1;
    assign hit_next = valid_reg && bytes_ok && window_reach[len_m1[IDX_W-1:0]];

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        len_reg  <= len_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

// ===== sv/word_break_segmenter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word break segmenter
// Decides whether a streamed text splits into words of a loaded dictionary.
// ----------------------------------------------------------------------------
// One input channel carries every request: s_tuser selects clear dictionary,
// dictionary byte or text byte, s_tdata holds the byte and s_tlast ends a
// word or the text. A clear or dictionary request leaves the block ready for the next request.
// A text byte passes through these steps in order: the window cells shift, every
// word cell registers its hit, the hits are OR-ed in registered groups of
// eight, and the final OR updates the reach bit of the newest position. That
// feedback through the word cells means no request is taken until that update is done.
// On a text byte with s_tlast set a single result appears on the m_ channel
// once the final OR is done: bit 0 says whether the text splits into
// words, bit 1 whether any word was dropped since the last clear. The text
// window then restarts. While a result waits in the output register, further
// requests are taken; a text end that finds the output register still full
// holds the block until the receiver takes the waiting result.
// Reset empties the dictionary and the text window; it is synchronous, taken at the clock edge.
// ----------------------------------------------------------------------------
module word_break_segmenter
    import wbs_pkg::*;
#(
    parameter int MAX_WORDS    = DEF_MAX_WORDS,
    parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] symbol
    input  logic [OP_W-1:0]  s_tuser,   // [1:0] operation
    input  logic             s_tlast,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata    // [0] segmentable, [1] words_dropped
);

    localparam int CNT_W      = $clog2(MAX_WORDS + 1);
    localparam int POS_W      = $clog2(MAX_WORD_LEN + 1);
    localparam int NUM_GROUPS = (MAX_WORDS + GROUP_SIZE - 1) / GROUP_SIZE;

    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_IDLE  = 2'd0;
    localparam logic [ST_W-1:0] ST_CELL  = 2'd1;
    localparam logic [ST_W-1:0] ST_GROUP = 2'd2;
    localparam logic [ST_W-1:0] ST_FINAL = 2'd3;

    logic [ST_W-1:0]  state_reg;
    logic [ST_W-1:0]  state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             overlong_reg;
    logic             overlong_next;
    logic             dropped_reg;
    logic             dropped_next;
    logic             reach0_reg;
    logic             reach0_next;
    logic             text_last_reg;
    logic             text_last_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [7:0]       m_tdata_reg;
    logic [7:0]       m_tdata_next;
    logic [NUM_GROUPS-1:0] group_reg;
    logic [NUM_GROUPS-1:0] group_next;

    logic             accept;
    logic             op_clear;
    logic             op_dict;
    logic             op_text;
    logic             pos_full;
    logic             overlong_now;
    logic             drop_word;
    logic             commit_ok;
    logic [POS_W-1:0] commit_len;
    logic             out_free;
    logic             finish;
    logic             final_reach;

    wbs_win_ctl_t                        win_ctl;
    logic [MAX_WORD_LEN-1:0][SYM_W-1:0]  win_bytes;
    logic [MAX_WORD_LEN-1:0]             win_reach;
    wbs_load_t [MAX_WORDS-1:0]           load_vec;
    logic [MAX_WORDS-1:0]                hit_vec;
    logic [NUM_GROUPS*GROUP_SIZE-1:0]    hit_pad;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign op_clear = accept && (s_tuser == OP_CLEAR);
    assign op_dict  = accept && (s_tuser == OP_DICT);
    assign op_text  = accept && (s_tuser == OP_TEXT);

    // Dictionary loading.
    assign pos_full     = (pos_reg == POS_W'(MAX_WORD_LEN));
    assign overlong_now = overlong_reg || pos_full;
    assign drop_word    = overlong_now || (count_reg == CNT_W'(MAX_WORDS));
    assign commit_ok    = op_dict && s_tlast && !drop_word;
    assign commit_len   = pos_reg + 1'b1;

    always_comb begin
        count_next    = count_reg;
        pos_next      = pos_reg;
        overlong_next = overlong_reg;
        dropped_next  = dropped_reg;
        priority if (op_clear) begin
            count_next    = '0;
            pos_next      = '0;
            overlong_next = 1'b0;
            dropped_next  = 1'b0;
        end else if (op_dict) begin
            if (pos_full) begin
                overlong_next = 1'b1;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
            if (s_tlast) begin
                pos_next      = '0;
                overlong_next = 1'b0;
                if (drop_word) begin
                    dropped_next = 1'b1;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int w = 0; w < MAX_WORDS; w++) begin
            load_vec[w].clear  = op_clear;
            load_vec[w].shift  = op_dict && !pos_full && (count_reg == CNT_W'(w));
            load_vec[w].commit = commit_ok && (count_reg == CNT_W'(w));
            load_vec[w].sym    = s_tdata;
        end
    end

    // Text sequencing.
    assign out_free    = !m_tvalid_reg || m_tready;
    assign final_reach = |group_reg;
    assign finish      = (state_reg == ST_FINAL) && (!text_last_reg || out_free);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (op_text) begin
                    state_next = ST_CELL;
                end
            end
            ST_CELL: begin
                state_next = ST_GROUP;
            end
            ST_GROUP: begin
                state_next = ST_FINAL;
            end
            ST_FINAL: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign text_last_next = op_text ? s_tlast : text_last_reg;
    assign win_ctl.shift   = op_text;
    assign win_ctl.restart = finish && text_last_reg;

    always_comb begin
        reach0_next = reach0_reg;
        if (finish) begin
            reach0_next = text_last_reg ? 1'b1 : final_reach;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (finish && text_last_reg) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'b0, dropped_reg, final_reach};
        end
    end

    always_comb begin
        hit_pad                  = '0;
        hit_pad[MAX_WORDS-1:0]   = hit_vec;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            group_next[g] = |hit_pad[g*GROUP_SIZE +: GROUP_SIZE];
        end
    end

    // Window cells: cell k holds the byte k positions back and the reach bit
    // of the position k + 1 bytes back.
    for (genvar k = 0; k < MAX_WORD_LEN; k++) begin : g_window
        if (k == 0) begin : g_head
            wbs_window_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (win_ctl),
                .byte_in   (s_tdata),
                .reach_in  (reach0_reg),
                .byte_out  (win_bytes[k]),
                .reach_out (win_reach[k])
            );
        end else begin : g_body
            wbs_window_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .ctl       (win_ctl),
                .byte_in   (win_bytes[k-1]),
                .reach_in  (win_reach[k-1]),
                .byte_out  (win_bytes[k]),
                .reach_out (win_reach[k])
            );
        end
    end

    for (genvar w = 0; w < MAX_WORDS; w++) begin : g_word
        wbs_word_cell #(
            .MAX_WORD_LEN (MAX_WORD_LEN)
        ) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .load         (load_vec[w]),
            .commit_len   (commit_len),
            .window_bytes (win_bytes),
            .window_reach (win_reach),
            .hit          (hit_vec[w])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pos_reg       <= '0;
            overlong_reg  <= 1'b0;
            dropped_reg   <= 1'b0;
            reach0_reg    <= 1'b1;
            text_last_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            overlong_reg  <= overlong_next;
            dropped_reg   <= dropped_next;
            reach0_reg    <= reach0_next;
            text_last_reg <= text_last_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        group_reg   <= group_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_WORDS))
        else $error("word count exceeds the dictionary capacity");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_WORD_LEN))
        else $error("load position exceeds the word length limit");

    a_one_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({commit_ok, op_clear}) <= 1)
        else $error("commit and clear in the same cycle");

    a_text_start: assert property (@(posedge aclk) disable iff (!aresetn)
        op_text |=> state_reg == ST_CELL)
        else $error("text request did not start the match sequence");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_FINAL && $past(text_last_reg))
        else $error("result raised outside the end of a text");
`endif

endmodule
